// ----- src/gptm_pkg.sv -----
`timescale 1ns / 1ps
package gptm_pkg;
    localparam int MAX_ROBOTS = 8;
    localparam int MAX_POINTS = 16;
    localparam int COORD_BITS = 12;
    localparam int RB = $clog2(MAX_ROBOTS);
    localparam int PB = $clog2(MAX_POINTS);
    localparam int DB = COORD_BITS + 1;
    localparam int QDEPTH = 4;
    localparam int QB = $clog2(QDEPTH);
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_POINT = 1'b1;
    localparam logic CFG_ROBOT_COUNT = 1'b0;
    localparam logic CFG_GATE = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [2:0]       robot_slot;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic             last_point;
    } t_item;

    typedef struct packed {
        logic [2:0]       match_slot;
        logic [COORD_BITS-1:0] match_x;
        logic [COORD_BITS-1:0] match_y;
        logic             matched;
        logic             last_result;
    } t_result;
endpackage

// ----- src/gptm_front.sv -----
`timescale 1ns / 1ps
module gptm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  gptm_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output gptm_pkg::t_item o_item
);
    gptm_pkg::t_item r_q [gptm_pkg::QDEPTH];
    logic [gptm_pkg::QB-1:0] r_wp, r_rp;
    logic [gptm_pkg::QB:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (gptm_pkg::QB+1)'(gptm_pkg::QDEPTH));
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != '0);
    assign pop = o_valid && i_ready;
    assign o_item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (gptm_pkg::QB+1)'(push) - (gptm_pkg::QB+1)'(pop);
        end
        if (push) r_q[r_wp] <= i_item;
    end
endmodule

// ----- src/gptm_back.sv -----
`timescale 1ns / 1ps
module gptm_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [3:0]            i_robot_count,
    input  logic [12:0]           i_gate,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  gptm_pkg::t_item       i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output gptm_pkg::t_result     o_res
);
    localparam int CB = gptm_pkg::COORD_BITS;
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_DIST = 4'b0100, S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    logic [CB-1:0] r_rx [gptm_pkg::MAX_ROBOTS];
    logic [CB-1:0] r_ry [gptm_pkg::MAX_ROBOTS];
    logic [CB-1:0] r_px [gptm_pkg::MAX_POINTS];
    logic [CB-1:0] r_py [gptm_pkg::MAX_POINTS];
    logic [gptm_pkg::PB:0] r_fill;
    logic [gptm_pkg::MAX_ROBOTS-1:0] r_rused;
    logic [gptm_pkg::MAX_POINTS-1:0] r_pused;
    logic [gptm_pkg::RB:0] r_nr;
    logic [gptm_pkg::RB-1:0] r_r, r_br, r_dr;
    logic [gptm_pkg::PB-1:0] r_p, r_bp, r_dp;
    logic [gptm_pkg::DB-1:0] r_best, r_d;
    logic r_found, r_dv, r_any;
    gptm_pkg::t_result r_out;
    gptm_pkg::t_result r_hold;
    logic r_ov;

    logic [CB-1:0] dx, dy;
    logic [gptm_pkg::DB-1:0] dsum;
    logic pair_ok, last_pair, out_free, emit_now;
    logic [gptm_pkg::RB:0] nr_sat;

    assign out_free = !r_ov || i_ready;
    assign emit_now = (r_state == S_EMIT) && out_free && (!r_found || r_any);
    assign o_valid = r_ov;
    assign o_res = r_out;
    assign o_ready = (r_state == S_IDLE);
    assign nr_sat = (i_robot_count > 4'(gptm_pkg::MAX_ROBOTS))
        ? (gptm_pkg::RB+1)'(gptm_pkg::MAX_ROBOTS) : (gptm_pkg::RB+1)'(i_robot_count);

    always_comb begin
        dx = (r_px[r_p] > r_rx[r_r]) ? r_px[r_p] - r_rx[r_r] : r_rx[r_r] - r_px[r_p];
        dy = (r_py[r_p] > r_ry[r_r]) ? r_py[r_p] - r_ry[r_r] : r_ry[r_r] - r_py[r_p];
        dsum = {1'b0, dx} + {1'b0, dy};
        pair_ok = !r_rused[r_r] && !r_pused[r_p] && ({1'b0, r_p} < r_fill);
        last_pair = ((gptm_pkg::RB+1)'(r_r) == r_nr - 1'b1)
            && ({1'b0, r_p} == r_fill - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_ov <= 1'b0;
            r_dv <= 1'b0;
            for (int i = 0; i < gptm_pkg::MAX_ROBOTS; i++) begin
                r_rx[i] <= '0;
                r_ry[i] <= '0;
            end
        end else begin
            if (emit_now) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_item.req_type == gptm_pkg::REQ_LOAD) begin
                            r_rx[i_item.robot_slot] <= i_item.pos_x;
                            r_ry[i_item.robot_slot] <= i_item.pos_y;
                        end else begin
                            if (r_fill < (gptm_pkg::PB+1)'(gptm_pkg::MAX_POINTS)) begin
                                r_px[r_fill[gptm_pkg::PB-1:0]] <= i_item.pos_x;
                                r_py[r_fill[gptm_pkg::PB-1:0]] <= i_item.pos_y;
                                r_fill <= r_fill + 1'b1;
                            end
                            if (i_item.last_point) begin
                                r_nr <= nr_sat;
                                r_rused <= '0;
                                r_pused <= '0;
                                r_any <= 1'b0;
                                r_state <= S_SCAN;
                                r_r <= '0;
                                r_p <= '0;
                                r_found <= 1'b0;
                                r_best <= '1;
                                r_dv <= 1'b0;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    // one pair per cycle, distance registered then compared
                    r_dv <= pair_ok && (r_nr != '0);
                    r_d <= dsum;
                    r_dr <= r_r;
                    r_dp <= r_p;
                    if ((r_nr == '0) || (r_fill == '0) || last_pair) begin
                        r_state <= S_DIST;
                    end else if ({1'b0, r_p} == r_fill - 1'b1) begin
                        r_p <= '0;
                        r_r <= r_r + 1'b1;
                    end else begin
                        r_p <= r_p + 1'b1;
                    end
                    if (r_dv && r_d < i_gate && r_d < r_best) begin
                        r_best <= r_d;
                        r_br <= r_dr;
                        r_bp <= r_dp;
                        r_found <= 1'b1;
                    end
                end
                S_DIST: begin
                    r_dv <= 1'b0;
                    if (r_dv && r_d < i_gate && r_d < r_best) begin
                        r_best <= r_d;
                        r_br <= r_dr;
                        r_bp <= r_dp;
                        r_found <= 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_found) begin
                            r_rx[r_br] <= r_px[r_bp];
                            r_ry[r_br] <= r_py[r_bp];
                            r_rused[r_br] <= 1'b1;
                            r_pused[r_bp] <= 1'b1;
                            r_any <= 1'b1;
                            // previous match goes out, this one waits
                            if (r_any) r_out <= r_hold;
                            r_hold <= '{match_slot: 3'(r_br), match_x: r_px[r_bp],
                                        match_y: r_py[r_bp], matched: 1'b1,
                                        last_result: 1'b0};
                            r_r <= '0;
                            r_p <= '0;
                            r_found <= 1'b0;
                            r_best <= '1;
                            r_state <= S_SCAN;
                        end else begin
                            if (r_any) begin
                                r_out <= '{match_slot: r_hold.match_slot,
                                           match_x: r_hold.match_x,
                                           match_y: r_hold.match_y,
                                           matched: 1'b1, last_result: 1'b1};
                            end else begin
                                r_out <= '{match_slot: '0, match_x: '0, match_y: '0,
                                           matched: 1'b0, last_result: 1'b1};
                            end
                            r_fill <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- src/greedy_point_track_matcher.sv -----
`timescale 1ns / 1ps
// Greedy nearest-neighbor matcher of detected points to up to 8 robot tracks.
// Load and detection transactions are queued (4 deep) and executed one at a
// time; loads and non-final detections are taken in the idle state. A final
// detection starts matching: each match round scans every robot/point pair
// at one pair per cycle, repeated once per match plus one closing round. The
// last match result is held back until the closing round and then issued with
// last_result set; a frame with no match gives one result with matched=0.
module greedy_point_track_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // robot_slot, pos_x, pos_y
    input  logic        s_axis_tuser,  // req_type
    input  logic        s_axis_tlast,  // last_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // match_slot, match_x, match_y
    output logic        m_axis_tuser,  // matched
    output logic        m_axis_tlast   // last_result
);
    logic [3:0]  r_robot_count;
    logic [12:0] r_gate;
    gptm_pkg::t_item in_item, q_item;
    gptm_pkg::t_result res;
    logic q_valid, q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_robot_count <= '0;
            r_gate <= 13'd10;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == gptm_pkg::CFG_ROBOT_COUNT) r_robot_count <= i_cfg_data[3:0];
            if (i_cfg_idx == gptm_pkg::CFG_GATE) r_gate <= i_cfg_data;
        end
    end

    assign in_item = '{req_type: s_axis_tuser, robot_slot: s_axis_tdata[2:0],
                       pos_x: s_axis_tdata[14:3], pos_y: s_axis_tdata[26:15],
                       last_point: s_axis_tlast};

    gptm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    gptm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_robot_count(r_robot_count), .i_gate(r_gate),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {5'd0, res.match_y, res.match_x, res.match_slot};
    assign m_axis_tuser = res.matched;
    assign m_axis_tlast = res.last_result;
endmodule
